FILE: sv/euler_rotation_matrix_defines.svh
// ============================================================================
// Euler rotation matrix assertion macros
// Shared assertion forms used by the pipeline modules.
// ============================================================================
`ifndef EULER_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ROTATION_MATRIX_DEFINES_SVH

// Assert a property that is checked on every rising clock edge outside reset.
`define ERM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that one condition implies another in the next cycle.
`define ERM_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error(msg);

`endif

FILE: sv/erm_pkg.sv
// ============================================================================
// Euler rotation matrix package
// Shared widths, constants, types and helper functions.
// ============================================================================
package erm_pkg;

  localparam int AngleWidth  = 16;
  localparam int OutFracBits = 14;
  localparam int OutWidth    = OutFracBits + 2;
  localparam int CordicSteps = 16;
  localparam int AngFrac     = AngleWidth - 4;
  localparam int AngShift    = 30 - AngFrac;
  localparam int QW          = 40;
  localparam int OutShift    = 30 - OutFracBits;

  localparam logic signed [QW-1:0] TwoPi  = 40'sd6746518852;
  localparam logic signed [QW-1:0] Pi     = 40'sd3373259426;
  localparam logic signed [QW-1:0] HalfPi = 40'sd1686629713;
  localparam logic signed [QW-1:0] Gain   = 40'sd652032874;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    logic neg;
  } cordic_t;

  typedef struct packed {
    q_t sx;
    q_t cx;
    q_t sy;
    q_t cy;
    q_t sz;
    q_t cz;
  } trig_t;

  function automatic q_t atan_q30(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
      27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return q_t'({8'd0, t});
  endfunction

  // Both factors stay within plus or minus 2.0 in Q2.30, so 32 bits carry them.
  function automatic q_t mul30(input q_t a, input q_t b);
    logic signed [31:0] a32, b32;
    logic signed [63:0] p;
    a32 = a[31:0];
    b32 = b[31:0];
    p = 64'(a32) * 64'(b32) + 64'sd536870912;
    return q_t'(p >>> 30);
  endfunction

  function automatic logic [OutWidth-1:0] out_of(input q_t v);
    q_t r;
    r = (v + (q_t'(1) <<< (OutShift - 1))) >>> OutShift;
    if (r > (q_t'(1) <<< OutFracBits)) begin
      r = q_t'(1) <<< OutFracBits;
    end
    if (r < -(q_t'(1) <<< OutFracBits)) begin
      r = -(q_t'(1) <<< OutFracBits);
    end
    return r[OutWidth-1:0];
  endfunction

endpackage

FILE: sv/erm_stream_if.sv
// ============================================================================
// Euler rotation matrix stream interfaces
// Valid/ready channels for angle words and matrix words.
// ============================================================================
interface erm_angle_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [erm_pkg::AngleWidth-1:0] angle_x;
  logic signed [erm_pkg::AngleWidth-1:0] angle_y;
  logic signed [erm_pkg::AngleWidth-1:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface erm_matrix_if;
  logic                                valid;
  logic                                ready;
  logic signed [erm_pkg::OutWidth-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                output ready);
endinterface

FILE: sv/erm_cordic_cell.sv
// ============================================================================
// Euler rotation matrix CORDIC cell
// One micro-rotation of the CORDIC chain for the three angles in flight.
// ============================================================================
module erm_cordic_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [4:0]          step_i,
  input  erm_pkg::cordic_t    a_i,
  input  erm_pkg::cordic_t    b_i,
  input  erm_pkg::cordic_t    c_i,
  output erm_pkg::cordic_t    a_o,
  output erm_pkg::cordic_t    b_o,
  output erm_pkg::cordic_t    c_o
);

  erm_pkg::cordic_t a_d, b_d, c_d;
  erm_pkg::cordic_t a_q, b_q, c_q;

  function automatic erm_pkg::cordic_t rot(input erm_pkg::cordic_t v, input logic [4:0] s);
    erm_pkg::cordic_t r;
    erm_pkg::q_t      dx, dy, at;
    dx = v.y >>> s;
    dy = v.x >>> s;
    at = erm_pkg::atan_q30(int'(s));
    r  = v;
    if (!v.z[erm_pkg::QW-1]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - at;
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + at;
    end
    return r;
  endfunction

  assign a_d = rot(a_i, step_i);
  assign b_d = rot(b_i, step_i);
  assign c_d = rot(c_i, step_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign c_o = c_q;

endmodule

FILE: sv/euler_rotation_matrix.sv
// ============================================================================
// Euler rotation matrix
// Rotation part of Rx*Ry*Rz from three Euler angles.
// ============================================================================
// The block takes one angle word per cycle while it is not stalled, and
// delivers one matrix word per word taken, in order. A word passes through
// CordicSteps + 4 = 20 registers: one range reduction stage, a chain of
// sixteen CORDIC cells, one sign stage and two product stages. The whole
// pipeline advances only when the output register is free or being taken,
// so ready follows that register.
`include "euler_rotation_matrix_defines.svh"

module euler_rotation_matrix (
  input  logic         clk_i,
  input  logic         rst_ni,
  erm_angle_if.sink    in_i,
  erm_matrix_if.source out_o
);

  localparam int Stages = erm_pkg::CordicSteps + 4;

  logic              en;
  logic [Stages-1:0] vld_q, vld_d;

  assign en       = !vld_q[Stages-1] || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    vld_d = {vld_q[Stages-2:0], in_i.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  function automatic erm_pkg::cordic_t reduce(input logic signed [erm_pkg::AngleWidth-1:0] a);
    erm_pkg::cordic_t c;
    erm_pkg::q_t      r;
    r = erm_pkg::q_t'(a) <<< erm_pkg::AngShift;
    if (r < 0) begin
      r = r + erm_pkg::TwoPi;
    end
    if (r < 0) begin
      r = r + erm_pkg::TwoPi;
    end
    if (r >= erm_pkg::TwoPi) begin
      r = r - erm_pkg::TwoPi;
    end
    if (r >= erm_pkg::TwoPi) begin
      r = r - erm_pkg::TwoPi;
    end
    if (r >= erm_pkg::Pi) begin
      r = r - erm_pkg::TwoPi;
    end
    c.neg = 1'b0;
    if (r > erm_pkg::HalfPi) begin
      r = r - erm_pkg::Pi;
      c.neg = 1'b1;
    end else if (r < -erm_pkg::HalfPi) begin
      r = r + erm_pkg::Pi;
      c.neg = 1'b1;
    end
    c.x = erm_pkg::Gain;
    c.y = '0;
    c.z = r;
    return c;
  endfunction

  erm_pkg::cordic_t ca [erm_pkg::CordicSteps+1];
  erm_pkg::cordic_t cb [erm_pkg::CordicSteps+1];
  erm_pkg::cordic_t cc [erm_pkg::CordicSteps+1];
  erm_pkg::cordic_t ra_q, rb_q, rc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q <= reduce(in_i.angle_x);
      rb_q <= reduce(in_i.angle_y);
      rc_q <= reduce(in_i.angle_z);
    end
  end

  assign ca[0] = ra_q;
  assign cb[0] = rb_q;
  assign cc[0] = rc_q;

  for (genvar g = 0; g < erm_pkg::CordicSteps; g++) begin : g_cell
    erm_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .step_i (5'(g)),
      .a_i    (ca[g]),
      .b_i    (cb[g]),
      .c_i    (cc[g]),
      .a_o    (ca[g+1]),
      .b_o    (cb[g+1]),
      .c_o    (cc[g+1])
    );
  end

  erm_pkg::trig_t t_q;
  erm_pkg::q_t    sxsy_q, cxsy_q, sy_q, cy_q, sx_q, cx_q, sz_q, cz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q.sx <= ca[erm_pkg::CordicSteps].neg ? -ca[erm_pkg::CordicSteps].y
                                               : ca[erm_pkg::CordicSteps].y;
      t_q.cx <= ca[erm_pkg::CordicSteps].neg ? -ca[erm_pkg::CordicSteps].x
                                               : ca[erm_pkg::CordicSteps].x;
      t_q.sy <= cb[erm_pkg::CordicSteps].neg ? -cb[erm_pkg::CordicSteps].y
                                               : cb[erm_pkg::CordicSteps].y;
      t_q.cy <= cb[erm_pkg::CordicSteps].neg ? -cb[erm_pkg::CordicSteps].x
                                               : cb[erm_pkg::CordicSteps].x;
      t_q.sz <= cc[erm_pkg::CordicSteps].neg ? -cc[erm_pkg::CordicSteps].y
                                               : cc[erm_pkg::CordicSteps].y;
      t_q.cz <= cc[erm_pkg::CordicSteps].neg ? -cc[erm_pkg::CordicSteps].x
                                               : cc[erm_pkg::CordicSteps].x;
      sxsy_q <= erm_pkg::mul30(t_q.sx, t_q.sy);
      cxsy_q <= erm_pkg::mul30(t_q.cx, t_q.sy);
      sy_q   <= t_q.sy;
      cy_q   <= t_q.cy;
      sx_q   <= t_q.sx;
      cx_q   <= t_q.cx;
      sz_q   <= t_q.sz;
      cz_q   <= t_q.cz;
      out_o.r00 <= erm_pkg::out_of(erm_pkg::mul30(cy_q, cz_q));
      out_o.r01 <= erm_pkg::out_of(erm_pkg::mul30(cy_q, sz_q));
      out_o.r02 <= erm_pkg::out_of(-sy_q);
      out_o.r10 <= erm_pkg::out_of(erm_pkg::mul30(sxsy_q, cz_q) - erm_pkg::mul30(cx_q, sz_q));
      out_o.r11 <= erm_pkg::out_of(erm_pkg::mul30(sxsy_q, sz_q) + erm_pkg::mul30(cx_q, cz_q));
      out_o.r12 <= erm_pkg::out_of(erm_pkg::mul30(sx_q, cy_q));
      out_o.r20 <= erm_pkg::out_of(erm_pkg::mul30(cxsy_q, cz_q) + erm_pkg::mul30(sx_q, sz_q));
      out_o.r21 <= erm_pkg::out_of(erm_pkg::mul30(cxsy_q, sz_q) - erm_pkg::mul30(sx_q, cz_q));
      out_o.r22 <= erm_pkg::out_of(erm_pkg::mul30(cx_q, cy_q));
    end
  end

  assign out_o.valid = vld_q[Stages-1];

  `ERM_ASSERT(a_ready_free, (!out_o.valid) |-> in_i.ready, "ready low with empty output")
  `ERM_ASSERT_NEXT(a_hold, out_o.valid && !out_o.ready, out_o.valid, "result word lost")
  `ERM_ASSERT_NEXT(a_advance, in_i.valid && in_i.ready, vld_q[0], "accepted word not tracked")

endmodule

FILE: tb/tb_euler_rotation_matrix.sv
// ============================================================================
// Euler rotation matrix testbench
// Drives angle words through the block with random gaps and stalls, and
// checks every matrix word against a bit-accurate predictor of Rx*Ry*Rz.
// ============================================================================
`timescale 1ns / 100ps

module tb_euler_rotation_matrix;

  typedef logic signed [erm_pkg::AngleWidth-1:0] ang_t;
  typedef logic signed [erm_pkg::OutWidth-1:0] ent_t;
  typedef struct packed {
    ent_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  } mat_t;
  typedef struct {
    ang_t ax, ay, az;
    bit   known;
    mat_t m;
  } row_t;

  localparam int RandItems = 500;
  localparam int WatchLimit = 4000;
  localparam longint QTwoPi = 64'sd6746518852;
  localparam longint QPi = 64'sd3373259426;
  localparam longint QHalfPi = 64'sd1686629713;
  localparam longint QGain = 64'sd652032874;
  localparam ent_t One = ent_t'(16384);
  localparam ent_t NegOne = ent_t'(-16384);
  localparam ent_t Zero = ent_t'(0);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  erm_angle_if in_if ();
  erm_matrix_if out_if ();

  euler_rotation_matrix u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mat_t   matrix_q[$];
  int     errors = 0;
  bit     send_done = 0;
  bit     hold_long = 0;
  int     idle_cycles = 0;
  longint atan_tab[16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fl_shift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic void sin_cos(ang_t a, output longint sn, output longint cs);
    longint r, x, y, z, dx, dy;
    bit neg;
    r = (longint'(a) <<< erm_pkg::AngShift) % QTwoPi;
    neg = 0;
    if (r < 0) r += QTwoPi;
    if (r >= QPi) r -= QTwoPi;
    if (r > QHalfPi) begin
      r -= QPi;
      neg = 1;
    end else if (r < -QHalfPi) begin
      r += QPi;
      neg = 1;
    end
    x = QGain;
    y = 0;
    z = r;
    for (int i = 0; i < erm_pkg::CordicSteps; i++) begin
      dx = fl_shift(y, i);
      dy = fl_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
  endfunction

  function automatic ent_t to_entry(longint v);
    longint r;
    r = fl_shift(v + (64'sd1 <<< (erm_pkg::OutShift - 1)), erm_pkg::OutShift);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return ent_t'(r);
  endfunction

  function automatic mat_t rotation(ang_t ax, ang_t ay, ang_t az);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    mat_t m;
    sin_cos(ax, sx, cx);
    sin_cos(ay, sy, cy);
    sin_cos(az, sz, cz);
    sxsy = qmul(sx, sy);
    cxsy = qmul(cx, sy);
    m.r00 = to_entry(qmul(cy, cz));
    m.r01 = to_entry(qmul(cy, sz));
    m.r02 = to_entry(-sy);
    m.r10 = to_entry(qmul(sxsy, cz) - qmul(cx, sz));
    m.r11 = to_entry(qmul(sxsy, sz) + qmul(cx, cz));
    m.r12 = to_entry(qmul(sx, cy));
    m.r20 = to_entry(qmul(cxsy, cz) + qmul(sx, sz));
    m.r21 = to_entry(qmul(cxsy, sz) - qmul(sx, cz));
    m.r22 = to_entry(qmul(cx, cy));
    return m;
  endfunction

  function automatic ang_t rand_angle();
    case ($urandom_range(0, 5))
      0: return ang_t'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
      1: return ang_t'($urandom_range(0, 12868) - 6434);
      default: return ang_t'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30))
                                      : int'($urandom_range(0, 2));
    if ($urandom_range(0, 2) == 0) gap = 0;
    return gap;
  endfunction

  row_t dir_tab[$];

  function automatic row_t mk(ang_t x, ang_t y, ang_t z, bit k, mat_t m);
    row_t r;
    r.ax = x; r.ay = y; r.az = z; r.known = k; r.m = m;
    return r;
  endfunction

  task automatic send_word(ang_t x, ang_t y, ang_t z, mat_t m, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.angle_x <= x;
    in_if.angle_y <= y;
    in_if.angle_z <= z;
    do @(posedge clk_i); while (!in_if.ready);
    matrix_q.push_back(m);
    @(negedge clk_i);
  endtask

  initial begin
    mat_t ident;
    ident = '{One, Zero, Zero, Zero, One, Zero, Zero, Zero, One};
    in_if.valid = 1'b0;
    in_if.angle_x = '0;
    in_if.angle_y = '0;
    in_if.angle_z = '0;
    dir_tab.push_back(mk(16'sd0, 16'sd0, 16'sd0, 0, ident));
    dir_tab.push_back(mk(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, ident));
    dir_tab.push_back(mk(16'sh8000, 16'sh8000, 16'sh8000, 0, ident));
    dir_tab.push_back(mk(16'sd6434, 16'sd0, 16'sd0, 0, ident));
    dir_tab.push_back(mk(16'sd0, 16'sd6434, 16'sd0, 0, ident));
    dir_tab.push_back(mk(16'sd0, 16'sd0, 16'sd6434, 0, ident));
    dir_tab.push_back(mk(16'sd12868, -16'sd12868, 16'sd25736, 0, ident));
    dir_tab.push_back(mk(-16'sd6434, 16'sd3217, -16'sd3217, 0, ident));
    dir_tab.push_back(mk(16'sh5555, 16'shAAAA, 16'sh0001, 0, ident));
    dir_tab.push_back(mk(-16'sd1, 16'sd1, 16'sh7FFF, 0, ident));
    dir_tab.push_back(mk(16'sd25735, 16'sd25736, 16'sd25737, 0, ident));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].ax, dir_tab[i].ay, dir_tab[i].az,
                dir_tab[i].known ? dir_tab[i].m
                                 : rotation(dir_tab[i].ax, dir_tab[i].ay, dir_tab[i].az),
                pick_gap());
    end
    hold_long = 1;
    for (int n = 0; n < RandItems; n++) begin
      ang_t x, y, z;
      x = rand_angle();
      y = rand_angle();
      z = rand_angle();
      send_word(x, y, z, rotation(x, y, z), (n < 60) ? 0 : pick_gap());
    end
    in_if.valid <= 1'b0;
    send_done = 1;
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        hold_long = 0;
        stall = 80;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 15) == 0) ? int'($urandom_range(5, 40))
                                             : int'($urandom_range(0, 2));
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mat_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.r00, out_if.r01, out_if.r02, out_if.r10, out_if.r11,
              out_if.r12, out_if.r20, out_if.r21, out_if.r22};
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected matrix word %h", $time, got);
        errors++;
      end else begin
        want = matrix_q.pop_front();
        if (got !== want) begin
          $display("%0t: matrix mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (send_done);
    while (matrix_q.size() != 0 && idle_cycles < WatchLimit) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (matrix_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WatchLimit);
    $display("tb: failure");
    $finish;
  end

endmodule
